// ===== hw/rtl/bpw_pkg.sv =====
// Shared types and fixed-point constants for the bright pixel whitener.
// Used by bpw_channel, bright_pixel_whitener and the testbench; depends on nothing else.
package bpw_pkg;

    // Rec.601 luma weights in Q8; they sum to 256.
    localparam logic [15:0] LUMA_W_BLUE  = 16'd29;
    localparam logic [15:0] LUMA_W_GREEN = 16'd150;
    localparam logic [15:0] LUMA_W_RED   = 16'd77;

    // Luma threshold (135 in Q8) and ramp span (110 in Q8).
    localparam logic [15:0] LUMA_THRESH = 16'd34560;
    localparam logic [14:0] LUMA_SPAN   = 15'd28160;

    // Strength in Q16: 0.30 plus 0.50 times openness, openness clamped to 256.
    localparam logic [15:0] STRENGTH_BASE  = 16'd19661;
    localparam int          STRENGTH_SHIFT = 7;
    localparam logic [8:0]  OPEN_FULL      = 9'd256;

    // The blend divides by 65536 * 28160 = 2^25 * 55. Half of that divisor
    // rounds to nearest, the shift takes out the power of two, and the
    // remaining divide by 55 is a multiply by ceil(2^20 / 55), which is exact
    // for every 14-bit dividend.
    localparam logic [39:0] ROUND_HALF   = 40'd922746880;
    localparam logic [14:0] RECIP_55     = 15'd19066;
    localparam int          RECIP_SHIFT  = 20;

    // Load enables for the three channel stages, from the pipeline control.
    typedef struct packed {
        logic ld_mul;
        logic ld_quot;
        logic ld_out;
    } bpw_adv_t;

endpackage

// ===== hw/rtl/bpw_channel.sv =====
// Blend datapath for one color channel: the last three pipeline stages.
// Depends on bpw_pkg for the rounding constants and the load-enable struct.
module bpw_channel (
    input  logic              clk,
    input  bpw_pkg::bpw_adv_t adv,
    input  logic [7:0]        chan,
    input  logic [30:0]       scale,
    output logic [7:0]        result
);

    logic [38:0] num_reg;
    logic [7:0]  chan_mul_reg;
    logic [28:0] prod_reg;
    logic [7:0]  chan_quot_reg;
    logic [7:0]  result_reg;

    logic [39:0] rounded;
    logic [13:0] quot_hi;
    logic [8:0]  quot;
    logic [8:0]  sum;
    logic [7:0]  result_next;

    // Stage one: scale times the headroom left above the channel value.
    always_ff @(posedge clk)
    begin
        if (adv.ld_mul)
        begin
            num_reg      <= 39'(scale) * 39'(8'd255 - chan);
            chan_mul_reg <= chan;
        end
    end

    // Stage two: add half the divisor, drop 2^25, multiply by 1/55.
    assign rounded = 40'(num_reg) + bpw_pkg::ROUND_HALF;
    assign quot_hi = rounded[38:25];

    always_ff @(posedge clk)
    begin
        if (adv.ld_quot)
        begin
            prod_reg      <= 29'(quot_hi) * 29'(bpw_pkg::RECIP_55);
            chan_quot_reg <= chan_mul_reg;
        end
    end

    // Stage three: add the increment and saturate at full scale.
    assign quot = prod_reg[28:bpw_pkg::RECIP_SHIFT];
    assign sum  = 9'(chan_quot_reg) + quot;

    always_comb
    begin
        if (sum[8])
        begin
            result_next = 8'd255;
        end
        else
        begin
            result_next = sum[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.ld_out)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== hw/rtl/bright_pixel_whitener.sv =====
// Bright pixel whitener top level: luma threshold and six-stage blend pipeline.
// Depends on bpw_pkg and on bpw_channel, one instance per color channel.
//
// Takes one BGR pixel per clock while out_stall is low and returns it with
// bright areas blended toward white. A pixel passes through six register
// stages (luma sum, threshold and clamp, strength multiply, headroom
// multiply, reciprocal multiply, saturate), the last of which is the output
// register. The rate is one pixel per cycle while out_stall is low. Stalls
// compact bubbles:
// a stage loads whenever it is empty or the stage after it moves, so in_stall
// rises only when all six stages hold a pixel and out_stall is high. The
// openness register is written through cfg_wr_en and cfg_wr_data and should
// only change while no pixel is in flight.
module bright_pixel_whitener (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [8:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] blue_in,
    input  logic [7:0] green_in,
    input  logic [7:0] red_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] blue_out,
    output logic [7:0] green_out,
    output logic [7:0] red_out,
    output logic       was_whitened
);

    localparam int NUM_STAGES = 6;

    // Pipeline control.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   rdy;

    // Configuration.
    logic [15:0] strength_reg;
    logic [15:0] strength_next;
    logic [8:0]  open_clamped;

    // Stage 0: pixel and luma sum.
    logic [7:0]  blue0_reg, green0_reg, red0_reg;
    logic [15:0] luma0_reg;
    logic [15:0] luma_next;

    // Stage 1: pixel, clamped excess and bright flag.
    logic [7:0]  blue1_reg, green1_reg, red1_reg;
    logic [14:0] excess1_reg;
    logic [14:0] excess_next;
    logic        bright1_reg;
    logic        bright_next;
    logic [15:0] over;

    // Stage 2: pixel and blend scale.
    logic [7:0]  blue2_reg, green2_reg, red2_reg;
    logic [30:0] scale2_reg;
    logic        bright2_reg;

    // Stages 3 to 5: bright flag alongside the channel datapaths.
    logic        bright3_reg, bright4_reg, bright5_reg;

    bpw_pkg::bpw_adv_t adv;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        rdy[NUM_STAGES] = !out_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        if (rdy[0])
        begin
            valid_next[0] = in_valid;
        end
        else
        begin
            valid_next[0] = valid_reg[0];
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // Openness clamps to one; strength is kept ready in Q16.
    assign open_clamped  = (cfg_wr_data > bpw_pkg::OPEN_FULL) ? bpw_pkg::OPEN_FULL
                                                              : cfg_wr_data;
    assign strength_next = bpw_pkg::STRENGTH_BASE
                         + (16'(open_clamped) << bpw_pkg::STRENGTH_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= bpw_pkg::STRENGTH_BASE;
        end
        else if (cfg_wr_en)
        begin
            strength_reg <= strength_next;
        end
    end

    // Stage 0: luma sum in Q8.
    assign luma_next = bpw_pkg::LUMA_W_BLUE  * 16'(blue_in)
                     + bpw_pkg::LUMA_W_GREEN * 16'(green_in)
                     + bpw_pkg::LUMA_W_RED   * 16'(red_in);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            blue0_reg  <= blue_in;
            green0_reg <= green_in;
            red0_reg   <= red_in;
            luma0_reg  <= luma_next;
        end
    end

    // Stage 1: excess over the threshold, clamped to the ramp span.
    // A dark pixel gets zero excess, which leaves every channel unchanged.
    assign over = luma0_reg - bpw_pkg::LUMA_THRESH;

    always_comb
    begin
        bright_next = luma0_reg > bpw_pkg::LUMA_THRESH;
        if (!bright_next)
        begin
            excess_next = '0;
        end
        else if (over > 16'(bpw_pkg::LUMA_SPAN))
        begin
            excess_next = bpw_pkg::LUMA_SPAN;
        end
        else
        begin
            excess_next = over[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            blue1_reg   <= blue0_reg;
            green1_reg  <= green0_reg;
            red1_reg    <= red0_reg;
            excess1_reg <= excess_next;
            bright1_reg <= bright_next;
        end
    end

    // Stage 2: blend scale is strength times excess.
    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            blue2_reg   <= blue1_reg;
            green2_reg  <= green1_reg;
            red2_reg    <= red1_reg;
            scale2_reg  <= 31'(strength_reg) * 31'(excess1_reg);
            bright2_reg <= bright1_reg;
        end
    end

    // Stages 3 to 5: the flag travels with the channel datapaths.
    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            bright3_reg <= bright2_reg;
        end
        if (rdy[4])
        begin
            bright4_reg <= bright3_reg;
        end
        if (rdy[5])
        begin
            bright5_reg <= bright4_reg;
        end
    end

    assign adv.ld_mul  = rdy[3];
    assign adv.ld_quot = rdy[4];
    assign adv.ld_out  = rdy[5];

    bpw_channel u_blue (
        .clk    (clk),
        .adv    (adv),
        .chan   (blue2_reg),
        .scale  (scale2_reg),
        .result (blue_out)
    );

    bpw_channel u_green (
        .clk    (clk),
        .adv    (adv),
        .chan   (green2_reg),
        .scale  (scale2_reg),
        .result (green_out)
    );

    bpw_channel u_red (
        .clk    (clk),
        .adv    (adv),
        .chan   (red2_reg),
        .scale  (scale2_reg),
        .result (red_out)
    );

    assign was_whitened = bright5_reg;

    // The input stalls only when every stage is full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg))
        else $error("input stalled with an empty pipeline stage");

    // A pixel leaving the first stage lands in the second.
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && rdy[1]) |=> valid_reg[1])
        else $error("pixel lost between the first two stages");

    // Strength stays between 0.30 and 0.80 in Q16.
    a_strength_range: assert property (@(posedge clk) disable iff (!rst_n)
        (strength_reg >= bpw_pkg::STRENGTH_BASE) && (strength_reg <= 16'd52429))
        else $error("blend strength out of range");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bright_pixel_whitener: directed table, then random pixels.
// Depends on bpw_pkg for the fixed-point constants and on the bright_pixel_whitener RTL.
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_PHASES = 5;
    localparam int PIXELS_PER_PHASE = 120;

    typedef enum logic { ROW_PIXEL, ROW_OPENNESS } row_kind_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       whitened;
    } pixel_result_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [8:0]    openness;
        logic [7:0]    blue;
        logic [7:0]    green;
        logic [7:0]    red;
        logic          has_typed;
        pixel_result_t typed;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [8:0] cfg_wr_data = 9'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] blue_in = 8'd0;
    logic [7:0] green_in = 8'd0;
    logic [7:0] red_in = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       was_whitened;

    // Predictor copy of the openness register and the results still owed by the block.
    logic [8:0]    openness_shadow = 9'd0;
    pixel_result_t pending_pixels[$];
    stim_row_t     directed_rows[$];

    int  mismatch_count = 0;
    int  pixels_sent = 0;
    int  pixels_checked = 0;
    int  whitened_seen = 0;
    int  openness_writes = 0;
    int  cycle_count = 0;

    // Receiver control: a flip of hold_flip requests one long hold-off.
    logic hold_flip = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   mode_left = 0;
    int   stall_mode = 0;

    bright_pixel_whitener DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .blue_in     (blue_in),
        .green_in    (green_in),
        .red_in      (red_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .blue_out    (blue_out),
        .green_out   (green_out),
        .red_out     (red_out),
        .was_whitened(was_whitened)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Blend one channel toward white by strength * excess, rounded half up and saturated.
    function automatic logic [7:0] blend_toward_white(input logic [7:0] chan,
                                                      input longint unsigned strength,
                                                      input longint unsigned excess);
        longint unsigned divisor;
        longint unsigned scaled;
        longint unsigned sum;
        divisor = 64'd65536 * longint'(bpw_pkg::LUMA_SPAN);
        scaled = strength * excess * (64'd255 - longint'(chan));
        sum = longint'(chan) + (scaled + divisor / 2) / divisor;
        return (sum > 64'd255) ? 8'd255 : sum[7:0];
    endfunction

    // Expected output for one pixel under the current openness setting.
    function automatic pixel_result_t whiten_pixel(input logic [7:0] b, input logic [7:0] g,
                                                   input logic [7:0] r);
        longint unsigned luma_q8;
        longint unsigned excess;
        longint unsigned open_q8;
        longint unsigned strength;
        pixel_result_t   res;
        luma_q8 = 29 * longint'(b) + 150 * longint'(g) + 77 * longint'(r);
        if (luma_q8 <= longint'(bpw_pkg::LUMA_THRESH))
        begin
            res = '{blue: b, green: g, red: r, whitened: 1'b0};
        end
        else
        begin
            excess = luma_q8 - longint'(bpw_pkg::LUMA_THRESH);
            if (excess > longint'(bpw_pkg::LUMA_SPAN))
                excess = longint'(bpw_pkg::LUMA_SPAN);
            open_q8 = longint'(openness_shadow);
            if (open_q8 > longint'(bpw_pkg::OPEN_FULL))
                open_q8 = longint'(bpw_pkg::OPEN_FULL);
            strength = longint'(bpw_pkg::STRENGTH_BASE) + (open_q8 << bpw_pkg::STRENGTH_SHIFT);
            res.blue = blend_toward_white(b, strength, excess);
            res.green = blend_toward_white(g, strength, excess);
            res.red = blend_toward_white(r, strength, excess);
            res.whitened = 1'b1;
        end
        return res;
    endfunction

    function automatic stim_row_t pixel_row(input logic [7:0] b, input logic [7:0] g,
                                            input logic [7:0] r, input logic has_typed,
                                            input pixel_result_t typed);
        stim_row_t row;
        row = '0;
        row.kind = ROW_PIXEL;
        row.blue = b;
        row.green = g;
        row.red = r;
        row.has_typed = has_typed;
        row.typed = typed;
        return row;
    endfunction

    function automatic stim_row_t openness_row(input logic [8:0] value);
        stim_row_t row;
        row = '0;
        row.kind = ROW_OPENNESS;
        row.openness = value;
        return row;
    endfunction

    // Append one row to the end of the directed table.
    task automatic add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Append one result to the end of the list of owed results.
    task automatic owe_result(input pixel_result_t res);
        pending_pixels.insert(pending_pixels.size(), res);
    endtask

    // Offer one pixel and hold it until the transfer happens, then record what it owes.
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                              input logic has_typed, input pixel_result_t typed);
        in_valid <= 1'b1;
        blue_in <= b;
        green_in <= g;
        red_in <= r;
        do
            @(posedge clk);
        while (in_stall);
        if (has_typed)
            owe_result(typed);
        else
            owe_result(whiten_pixel(b, g, r));
        pixels_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // The register is only written once the pipeline is empty.
    task automatic write_openness(input logic [8:0] value);
        drain_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        openness_shadow = value;
        openness_writes++;
    endtask

    // Random pixel: uniform, bright, near the luma threshold, or built from corner values.
    task automatic pick_pixel(output logic [7:0] b, output logic [7:0] g, output logic [7:0] r);
        int flavor;
        int need;
        int gval;
        logic [7:0] corners[6];
        corners = '{8'd0, 8'd1, 8'd254, 8'd255, 8'h55, 8'hAA};
        flavor = $urandom_range(0, 99);
        b = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        r = 8'($urandom_range(0, 255));
        if (flavor < 30)
        begin
            b = 8'($urandom_range(150, 255));
            g = 8'($urandom_range(150, 255));
            r = 8'($urandom_range(150, 255));
        end
        else if (flavor < 45)
        begin
            need = int'(bpw_pkg::LUMA_THRESH) - 29 * int'(b) - 77 * int'(r);
            if (need >= 0 && need <= 150 * 255)
            begin
                gval = need / 150 + $urandom_range(0, 2) - 1;
                if (gval < 0)
                    gval = 0;
                if (gval > 255)
                    gval = 255;
                g = gval[7:0];
            end
        end
        else if (flavor < 60)
        begin
            b = corners[$urandom_range(0, 5)];
            g = corners[$urandom_range(0, 5)];
            r = corners[$urandom_range(0, 5)];
        end
    endtask

    // Receiver: random stall pattern (never, one in five, or six in ten), with one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_flip != hold_seen)
        begin
            hold_seen <= hold_flip;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left <= $urandom_range(20, 80);
                stall_mode <= $urandom_range(0, 2);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 4) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 6);
            endcase
        end
    end

    // Check each output transfer against the oldest owed result.
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected output transfer b=%0d g=%0d r=%0d w=%0d",
                         $time, blue_out, green_out, red_out, was_whitened);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (was_whitened)
                    whitened_seen++;
                if (blue_out !== want.blue)
                begin
                    $display("%0t: blue_out expected %0d, got %0d", $time, want.blue, blue_out);
                    mismatch_count++;
                end
                if (green_out !== want.green)
                begin
                    $display("%0t: green_out expected %0d, got %0d", $time, want.green,
                             green_out);
                    mismatch_count++;
                end
                if (red_out !== want.red)
                begin
                    $display("%0t: red_out expected %0d, got %0d", $time, want.red, red_out);
                    mismatch_count++;
                end
                if (was_whitened !== want.whitened)
                begin
                    $display("%0t: was_whitened expected %0d, got %0d", $time, want.whitened,
                             was_whitened);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results still owed", $time, pending_pixels.size());
            $display("[bright_pixel_whitener] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [7:0]    b;
        logic [7:0]    g;
        logic [7:0]    r;
        logic [8:0]    phase_openness[RANDOM_PHASES];
        int            sent_in_phase;
        int            burst_len;
        pixel_result_t none;
        none = '0;

        // Directed rows. Typed results: black, white, the exact threshold, the blue and red primaries.
        add_row(pixel_row(8'd0, 8'd0, 8'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}));
        add_row(pixel_row(8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}));
        add_row(pixel_row(8'd90, 8'd213, 8'd0, 1'b1, '{8'd90, 8'd213, 8'd0, 1'b0}));
        add_row(pixel_row(8'd91, 8'd213, 8'd0, 1'b0, none));
        add_row(pixel_row(8'd255, 8'd0, 8'd0, 1'b1, '{8'd255, 8'd0, 8'd0, 1'b0}));
        add_row(pixel_row(8'd0, 8'd0, 8'd255, 1'b1, '{8'd0, 8'd0, 8'd255, 1'b0}));
        add_row(pixel_row(8'd0, 8'd255, 8'd0, 1'b0, none));
        add_row(pixel_row(8'hAA, 8'h55, 8'hAA, 1'b0, none));
        add_row(pixel_row(8'h55, 8'hAA, 8'h55, 1'b0, none));
        add_row(openness_row(9'd256));
        add_row(pixel_row(8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}));
        add_row(pixel_row(8'd0, 8'd255, 8'd255, 1'b0, none));
        add_row(pixel_row(8'd200, 8'd240, 8'd230, 1'b0, none));
        // Openness above one is treated as fully open.
        add_row(openness_row(9'd511));
        add_row(pixel_row(8'd0, 8'd255, 8'd255, 1'b0, none));
        add_row(pixel_row(8'd0, 8'd0, 8'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}));
        add_row(pixel_row(8'd254, 8'd254, 8'd254, 1'b0, none));
        add_row(openness_row(9'd300));
        add_row(pixel_row(8'd1, 8'd255, 8'd255, 1'b0, none));
        add_row(openness_row(9'd0));
        add_row(pixel_row(8'd0, 8'd255, 8'd255, 1'b0, none));
        add_row(pixel_row(8'd128, 8'd255, 8'd200, 1'b0, none));

        phase_openness[0] = 9'd256;
        phase_openness[1] = 9'(257 + $urandom_range(0, 254));
        phase_openness[2] = 9'($urandom_range(1, 255));
        phase_openness[3] = 9'd0;
        phase_openness[4] = 9'($urandom_range(0, 511));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_OPENNESS)
                write_openness(directed_rows[i].openness);
            else
                send_pixel(directed_rows[i].blue, directed_rows[i].green,
                           directed_rows[i].red, directed_rows[i].has_typed,
                           directed_rows[i].typed);
        end

        // Random part: bursts with gaps, one openness setting per phase.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_openness(phase_openness[phase]);
            sent_in_phase = 0;
            if (phase == 0)
            begin
                // Long receiver hold-off while a gapless burst keeps coming, so the pipe fills.
                hold_flip <= ~hold_flip;
                for (int k = 0; k < 40; k++)
                begin
                    pick_pixel(b, g, r);
                    send_pixel(b, g, r, 1'b0, none);
                end
                sent_in_phase = 40;
            end
            while (sent_in_phase < PIXELS_PER_PHASE)
            begin
                burst_len = $urandom_range(1, 30);
                for (int k = 0; k < burst_len && sent_in_phase < PIXELS_PER_PHASE; k++)
                begin
                    pick_pixel(b, g, r);
                    send_pixel(b, g, r, 1'b0, none);
                    sent_in_phase++;
                    if ($urandom_range(0, 5) == 0)
                        pause_sender($urandom_range(1, 3));
                end
                if ($urandom_range(0, 7) == 0)
                    drain_pipeline();
                else
                    pause_sender($urandom_range(0, 8));
            end
        end

        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d of %0d pixels, %0d of them whitened, across %0d openness writes.",
                 pixels_checked, pixels_sent, whitened_seen, openness_writes);
        if (mismatch_count == 0)
            $display("[bright_pixel_whitener] OK");
        else
            $display("[bright_pixel_whitener] ERROR");
        $finish;
    end

endmodule
